FILE: rtl/cmic_pkg.sv
package cmic_pkg;

  // Main status bits that summarise the cascaded secondary groups.
  localparam logic [31:0] GROUP_BITS    = 32'h0000_0070;
  localparam logic [31:0] GRP_HIGH_MAIN = 32'h0000_0010;
  localparam logic [31:0] GRP_MID_MAIN  = 32'h0000_0020;
  localparam logic [31:0] GRP_LOW_MAIN  = 32'h0000_0040;
  localparam logic [31:0] GRP_HIGH_SEC  = 32'hFFFF_0000;
  localparam logic [31:0] GRP_MID_SEC   = 32'h0000_FF00;
  localparam logic [31:0] GRP_LOW_SEC   = 32'h0000_00FF;

  // Reset values of the edge configuration registers.
  localparam logic [31:0] MAIN_EDGE_RESET = 32'h71CF_0000;
  localparam logic [31:0] SEC_EDGE_RESET  = 32'h1041_0000;

  // IRQ numbering: main IRQs start at one, secondary IRQs follow the main ones.
  localparam logic [6:0] IRQ_FIRST_MAIN = 7'd1;
  localparam logic [6:0] IRQ_LAST_MAIN  = 7'd32;
  localparam logic [6:0] IRQ_FIRST_SEC  = 7'd33;
  localparam logic [6:0] IRQ_LAST_SEC   = 7'd64;

  // Configuration register indexes.
  localparam logic CFG_MAIN_EDGE = 1'b0;
  localparam logic CFG_SEC_EDGE  = 1'b1;

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_ENABLE  = 2'd1,
    ACT_DISABLE = 2'd2,
    ACT_ACK     = 2'd3
  } action_e;

  // Architectural state carried from one item to the next.
  typedef struct packed {
    logic [31:0] main_mask;
    logic [31:0] sec_mask;
    logic [31:0] main_latch;
    logic [31:0] sec_latch;
    logic [31:0] main_prev;
    logic [31:0] sec_prev;
  } state_t;

  // One result item.
  typedef struct packed {
    logic        pending;
    logic [6:0]  number;
    logic [31:0] main_status;
    logic [31:0] sec_status;
    logic [31:0] main_mask;
    logic [31:0] sec_mask;
  } result_t;

  // Index of the lowest set bit, zero when none is set. The lowest bit is
  // isolated first, then its position is gathered by independent OR terms.
  function automatic logic [4:0] lowest_index(input logic [31:0] v);
    logic [31:0] low;
    logic [4:0]  idx;
    low = v & (~v + 32'd1);
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (low[i]) begin
        idx = idx | 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/cmic_eval.sv
module cmic_eval (
  input  cmic_pkg::state_t  cur_i,
  input  cmic_pkg::action_e act_i,
  input  logic [6:0]        irq_sel_i,
  input  logic [31:0]       main_lines_i,
  input  logic [31:0]       sec_lines_i,
  input  logic [31:0]       main_edge_i,
  input  logic [31:0]       sec_edge_i,
  output cmic_pkg::state_t  nxt_o,
  output cmic_pkg::result_t res_o
);

  logic        cmd_ok;
  logic        is_main;
  logic [4:0]  main_off;
  logic [4:0]  sec_off;
  logic [31:0] main_bit;
  logic [31:0] sec_bit;
  logic [31:0] mmask;
  logic [31:0] smask;
  logic [31:0] mlatch;
  logic [31:0] slatch;
  logic [31:0] ml;
  logic [31:0] sstat;
  logic [31:0] spend;
  logic [31:0] mstat;
  logic [31:0] mpend;
  logic        grp_first;
  logic [6:0]  number;

  // Command stage: the command acts on the masks and latches before sampling.
  always_comb begin
    cmd_ok   = (act_i != cmic_pkg::ACT_SAMPLE) && (irq_sel_i >= cmic_pkg::IRQ_FIRST_MAIN)
               && (irq_sel_i <= cmic_pkg::IRQ_LAST_SEC);
    is_main  = irq_sel_i <= cmic_pkg::IRQ_LAST_MAIN;
    main_off = 5'(irq_sel_i - cmic_pkg::IRQ_FIRST_MAIN);
    sec_off  = 5'(irq_sel_i - cmic_pkg::IRQ_FIRST_SEC);
    main_bit = 32'd1 << main_off;
    sec_bit  = 32'd1 << sec_off;
    mmask    = cur_i.main_mask;
    smask    = cur_i.sec_mask;
    mlatch   = cur_i.main_latch;
    slatch   = cur_i.sec_latch;
    if (cmd_ok) begin
      if (is_main) begin
        if (act_i == cmic_pkg::ACT_ENABLE) begin
          mmask = mmask | main_bit;
        end else begin
          if (act_i == cmic_pkg::ACT_ACK) begin
            mlatch = mlatch & ~main_bit;
          end
          mmask = mmask & ~main_bit;
        end
      end else begin
        if (act_i == cmic_pkg::ACT_ENABLE) begin
          // Enabling a secondary source also opens its group on the main level.
          if (sec_off < 5'd8) begin
            mmask = mmask | cmic_pkg::GRP_LOW_MAIN;
          end else if (sec_off < 5'd16) begin
            mmask = mmask | cmic_pkg::GRP_MID_MAIN;
          end else begin
            mmask = mmask | cmic_pkg::GRP_HIGH_MAIN;
          end
          smask = smask | sec_bit;
        end else begin
          if (act_i == cmic_pkg::ACT_ACK) begin
            slatch = slatch & ~sec_bit;
          end
          smask = smask & ~sec_bit;
          // Any group left with no enabled source is closed on the main level.
          if ((smask & cmic_pkg::GRP_LOW_SEC) == '0) begin
            mmask = mmask & ~cmic_pkg::GRP_LOW_MAIN;
          end
          if ((smask & cmic_pkg::GRP_MID_SEC) == '0) begin
            mmask = mmask & ~cmic_pkg::GRP_MID_MAIN;
          end
          if ((smask & cmic_pkg::GRP_HIGH_SEC) == '0) begin
            mmask = mmask & ~cmic_pkg::GRP_HIGH_MAIN;
          end
        end
      end
    end
  end

  // Sampling, status and priority.
  always_comb begin
    ml     = main_lines_i & ~cmic_pkg::GROUP_BITS;
    sstat  = '0;
    // Rising edges on edge-configured sources set their latches.
    nxt_o.main_latch = mlatch | (ml & ~cur_i.main_prev & main_edge_i & ~cmic_pkg::GROUP_BITS);
    nxt_o.sec_latch  = slatch | (sec_lines_i & ~cur_i.sec_prev & sec_edge_i);
    nxt_o.main_prev  = ml;
    nxt_o.sec_prev   = sec_lines_i;
    nxt_o.main_mask  = mmask;
    nxt_o.sec_mask   = smask;

    sstat = (sec_lines_i & ~sec_edge_i) | nxt_o.sec_latch;
    spend = sstat & smask;
    mstat = ((ml & ~main_edge_i) | nxt_o.main_latch) & ~cmic_pkg::GROUP_BITS;
    if ((spend & cmic_pkg::GRP_HIGH_SEC) != '0) begin
      mstat = mstat | cmic_pkg::GRP_HIGH_MAIN;
    end
    if ((spend & cmic_pkg::GRP_MID_SEC) != '0) begin
      mstat = mstat | cmic_pkg::GRP_MID_MAIN;
    end
    if ((spend & cmic_pkg::GRP_LOW_SEC) != '0) begin
      mstat = mstat | cmic_pkg::GRP_LOW_MAIN;
    end
    mpend = mstat & mmask;

    // A group bit winning on the main level hands over to the secondary sources.
    grp_first = ((mpend & (~mpend + 32'd1)) & cmic_pkg::GROUP_BITS) != '0;
    if (mpend == '0) begin
      number = '0;
    end else if (grp_first) begin
      number = cmic_pkg::IRQ_FIRST_SEC + {2'b00, cmic_pkg::lowest_index(spend)};
    end else begin
      number = cmic_pkg::IRQ_FIRST_MAIN + {2'b00, cmic_pkg::lowest_index(mpend)};
    end

    res_o.pending     = mpend != '0;
    res_o.number      = number;
    res_o.main_status = mstat;
    res_o.sec_status  = sstat;
    res_o.main_mask   = mmask;
    res_o.sec_mask    = smask;
  end

endmodule

FILE: rtl/cascaded_masked_interrupt_controller.sv
// Flow: an item accepted into the input register has its result registered once the
// output register is free or being emptied; a stall on the output holds it there.
// Throughput: one item per cycle while the output is not stalled; masks and latches are updated in the same cycle
// that an item moves from the input register into the result register.
// Reset: masks, edge latches and previous line levels clear; the edge configuration
// registers return to their reset values; both item registers are emptied.
module cascaded_masked_interrupt_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [6:0]  irq_select_i,
  input  logic [31:0] main_lines_i,
  input  logic [31:0] secondary_lines_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        irq_pending_o,
  output logic [6:0]  irq_number_o,
  output logic [31:0] main_status_o,
  output logic [31:0] secondary_status_o,
  output logic [31:0] main_mask_now_o,
  output logic [31:0] secondary_mask_now_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0]       main_edge_q;
  logic [31:0]       sec_edge_q;
  cmic_pkg::state_t  state_q;
  cmic_pkg::state_t  state_d;
  cmic_pkg::result_t res_d;
  cmic_pkg::result_t res_q;
  logic              in_valid_q;
  cmic_pkg::action_e act_q;
  logic [6:0]        irq_sel_q;
  logic [31:0]       main_lines_q;
  logic [31:0]       sec_lines_q;
  logic              out_valid_q;
  logic              advance;

  // The input register moves on whenever the result register is free or being emptied.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_edge_q <= cmic_pkg::MAIN_EDGE_RESET;
      sec_edge_q  <= cmic_pkg::SEC_EDGE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == cmic_pkg::CFG_MAIN_EDGE) begin
        main_edge_q <= cfg_wdata_i;
      end else begin
        sec_edge_q <= cfg_wdata_i;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q        <= cmic_pkg::action_e'(action_i);
      irq_sel_q    <= irq_select_i;
      main_lines_q <= main_lines_i;
      sec_lines_q  <= secondary_lines_i;
    end
  end

  cmic_eval u_eval (
    .cur_i        (state_q),
    .act_i        (act_q),
    .irq_sel_i    (irq_sel_q),
    .main_lines_i (main_lines_q),
    .sec_lines_i  (sec_lines_q),
    .main_edge_i  (main_edge_q),
    .sec_edge_i   (sec_edge_q),
    .nxt_o        (state_d),
    .res_o        (res_d)
  );

  // Controller state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign irq_pending_o        = res_q.pending;
  assign irq_number_o         = res_q.number;
  assign main_status_o        = res_q.main_status;
  assign secondary_status_o   = res_q.sec_status;
  assign main_mask_now_o      = res_q.main_mask;
  assign secondary_mask_now_o = res_q.sec_mask;

  // A reported IRQ number is non-zero exactly when something is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.pending == (res_q.number != 7'd0)))
    else $error("irq number disagrees with pending flag");

  // Group summary bits never hold a latch or a previous level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q.main_latch | state_q.main_prev) & cmic_pkg::GROUP_BITS) == '0)
    else $error("group bit found in main latch or previous levels");

  // An item held in the input register is not dropped while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("stalled item lost from input register");

  // A stalled result stays valid, and the controller state only changes when the result item is taken or it is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(state_q)))
    else $error("controller state changed while result stalled");

endmodule

FILE: tb/irq_report_checker.sv
module irq_report_checker
  import cmic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [6:0]  irq_select_i,
  input  logic [31:0] main_lines_i,
  input  logic [31:0] secondary_lines_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        irq_pending_i,
  input  logic [6:0]  irq_number_i,
  input  logic [31:0] main_status_i,
  input  logic [31:0] secondary_status_i,
  input  logic [31:0] main_mask_now_i,
  input  logic [31:0] secondary_mask_now_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output int          mismatch_count_o,
  output int          reports_due_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Private copy of the controller state and its edge configuration.
  logic [31:0] main_edge_sel;
  logic [31:0] sec_edge_sel;
  logic [31:0] main_enable;
  logic [31:0] sec_enable;
  logic [31:0] main_held;
  logic [31:0] sec_held;
  logic [31:0] main_last;
  logic [31:0] sec_last;

  result_t reports_due[$];
  int      mismatches;

  initial begin
    mismatch_count_o = 0;
    reports_due_o    = 0;
  end

  function automatic int unsigned first_set(input logic [31:0] v);
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        return i;
      end
    end
    return 0;
  endfunction

  // Applies one item's command, samples its lines and forms the report.
  function automatic result_t resolve_interrupts(input action_e act, input logic [6:0] irq,
                                                 input logic [31:0] main_raw,
                                                 input logic [31:0] sec_raw);
    result_t     rep;
    logic [31:0] main_in;
    logic [31:0] sel_bit;
    logic [31:0] sec_stat;
    logic [31:0] sec_pend;
    logic [31:0] main_stat;
    logic [31:0] main_pend;
    int unsigned pos;

    main_in = main_raw & ~GROUP_BITS;

    // The command takes effect before the lines are sampled.
    if (act != ACT_SAMPLE && irq >= IRQ_FIRST_MAIN && irq <= IRQ_LAST_SEC) begin
      if (irq <= IRQ_LAST_MAIN) begin
        sel_bit = 32'd1 << (irq - IRQ_FIRST_MAIN);
        if (act == ACT_ENABLE) begin
          main_enable |= sel_bit;
        end else begin
          if (act == ACT_ACK) begin
            main_held &= ~sel_bit;
          end
          main_enable &= ~sel_bit;
        end
      end else begin
        pos     = irq - IRQ_FIRST_SEC;
        sel_bit = 32'd1 << pos;
        if (act == ACT_ENABLE) begin
          sec_enable |= sel_bit;
          if (pos < 8) begin
            main_enable |= GRP_LOW_MAIN;
          end else if (pos < 16) begin
            main_enable |= GRP_MID_MAIN;
          end else begin
            main_enable |= GRP_HIGH_MAIN;
          end
        end else begin
          if (act == ACT_ACK) begin
            sec_held &= ~sel_bit;
          end
          sec_enable &= ~sel_bit;
          // A group whose secondary enables are all gone loses its main enable.
          if ((sec_enable & GRP_LOW_SEC) == '0) main_enable &= ~GRP_LOW_MAIN;
          if ((sec_enable & GRP_MID_SEC) == '0) main_enable &= ~GRP_MID_MAIN;
          if ((sec_enable & GRP_HIGH_SEC) == '0) main_enable &= ~GRP_HIGH_MAIN;
        end
      end
    end

    // Rising edges on edge-selected sources latch until acknowledged.
    main_held |= main_in & ~main_last & main_edge_sel & ~GROUP_BITS;
    sec_held  |= sec_raw & ~sec_last & sec_edge_sel;
    main_last  = main_in;
    sec_last   = sec_raw;

    sec_stat  = (sec_raw & ~sec_edge_sel) | sec_held;
    sec_pend  = sec_stat & sec_enable;
    main_stat = ((main_in & ~main_edge_sel) | main_held) & ~GROUP_BITS;
    if ((sec_pend & GRP_HIGH_SEC) != '0) main_stat |= GRP_HIGH_MAIN;
    if ((sec_pend & GRP_MID_SEC) != '0) main_stat |= GRP_MID_MAIN;
    if ((sec_pend & GRP_LOW_SEC) != '0) main_stat |= GRP_LOW_MAIN;
    main_pend = main_stat & main_enable;

    // Lowest pending main source wins; a group bit hands over to the secondaries.
    rep.pending = (main_pend != '0);
    rep.number  = '0;
    if (rep.pending) begin
      pos = first_set(main_pend);
      if ((GROUP_BITS & (32'd1 << pos)) != '0) begin
        rep.number = 7'(IRQ_FIRST_SEC + first_set(sec_pend));
      end else begin
        rep.number = 7'(pos + 1);
      end
    end
    rep.main_status = main_stat;
    rep.sec_status  = sec_stat;
    rep.main_mask   = main_enable;
    rep.sec_mask    = sec_enable;
    return rep;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Predict on every accepted input item and check every accepted result item.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      main_edge_sel = MAIN_EDGE_RESET;
      sec_edge_sel  = SEC_EDGE_RESET;
      main_enable   = '0;
      sec_enable    = '0;
      main_held     = '0;
      sec_held      = '0;
      main_last     = '0;
      sec_last      = '0;
      mismatches    = 0;
      reports_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MAIN_EDGE) begin
          main_edge_sel = cfg_wdata_i;
        end else begin
          sec_edge_sel = cfg_wdata_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        reports_due.push_back(resolve_interrupts(action_e'(action_i), irq_select_i,
                                                 main_lines_i, secondary_lines_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (reports_due.size() == 0) begin
          $display("%0t: result item with none expected, number %0d", $time, irq_number_i);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          compare_field("irq_pending", 32'(want.pending), 32'(irq_pending_i));
          compare_field("irq_number", 32'(want.number), 32'(irq_number_i));
          compare_field("main_status", want.main_status, main_status_i);
          compare_field("secondary_status", want.sec_status, secondary_status_i);
          compare_field("main_mask_now", want.main_mask, main_mask_now_i);
          compare_field("secondary_mask_now", want.sec_mask, secondary_mask_now_i);
        end
      end
    end
    reports_due_o    <= reports_due.size();
    mismatch_count_o <= mismatches;
  end

endmodule

FILE: tb/cascaded_masked_interrupt_controller_tb.sv
module cascaded_masked_interrupt_controller_tb;

  import cmic_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned ITEMS_PER_SET = 100;
  localparam int unsigned EDGE_SETS     = 6;

  typedef enum logic [1:0] {
    MODE_RX_SLOW,
    MODE_TX_SLOW,
    MODE_STEADY
  } idle_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [6:0]  irq_select_i;
  logic [31:0] main_lines_i;
  logic [31:0] secondary_lines_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        irq_pending_o;
  logic [6:0]  irq_number_o;
  logic [31:0] main_status_o;
  logic [31:0] secondary_status_o;
  logic [31:0] main_mask_now_o;
  logic [31:0] secondary_mask_now_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_wdata_i;

  idle_mode_e  idle_mode;
  int          mismatch_count;
  int          reports_due;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;
  int unsigned quiet_cycles   = 0;

  cascaded_masked_interrupt_controller dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .irq_select_i         (irq_select_i),
    .main_lines_i         (main_lines_i),
    .secondary_lines_i    (secondary_lines_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .irq_pending_o        (irq_pending_o),
    .irq_number_o         (irq_number_o),
    .main_status_o        (main_status_o),
    .secondary_status_o   (secondary_status_o),
    .main_mask_now_o      (main_mask_now_o),
    .secondary_mask_now_o (secondary_mask_now_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  irq_report_checker checker_inst (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .action_i             (action_i),
    .irq_select_i         (irq_select_i),
    .main_lines_i         (main_lines_i),
    .secondary_lines_i    (secondary_lines_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .irq_pending_i        (irq_pending_o),
    .irq_number_i         (irq_number_o),
    .main_status_i        (main_status_o),
    .secondary_status_i   (secondary_status_o),
    .main_mask_now_i      (main_mask_now_o),
    .secondary_mask_now_i (secondary_mask_now_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .mismatch_count_o     (mismatch_count),
    .reports_due_o        (reports_due)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: random back-pressure, plus one long hold-off once the steady
  // phase begins so that the block fills up and stalls its input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (idle_mode == MODE_STEADY && !long_hold_done) begin
      out_ready_i    <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (idle_mode == MODE_RX_SLOW) begin
      out_ready_i <= ($urandom_range(99) >= 69);
    end else if (idle_mode == MODE_TX_SLOW) begin
      out_ready_i <= ($urandom_range(99) >= 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Ends the run if nothing at all is accepted for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one input item after an optional gap and waits until it is taken.
  task automatic send_item(input action_e act, input logic [6:0] irq,
                           input logic [31:0] main_lv, input logic [31:0] sec_lv);
    int unsigned gap;
    int unsigned pct;
    gap = 0;
    pct = (idle_mode == MODE_TX_SLOW) ? 69 : (idle_mode == MODE_RX_SLOW) ? 7 : 0;
    while ($urandom_range(99) < pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    action_i          <= act;
    irq_select_i      <= irq;
    main_lines_i      <= main_lv;
    secondary_lines_i <= sec_lv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reports_due != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_edges(input logic [31:0] main_sel, input logic [31:0] sec_sel);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MAIN_EDGE;
    cfg_wdata_i <= main_sel;
    @(posedge clk_i);
    cfg_index_i <= CFG_SEC_EDGE;
    cfg_wdata_i <= sec_sel;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] main_edge_set [EDGE_SETS];
    logic [31:0] sec_edge_set [EDGE_SETS];
    logic [31:0] main_wave;
    logic [31:0] sec_wave;
    logic [6:0]  irq;
    action_e     act;

    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    action_i          = ACT_SAMPLE;
    irq_select_i      = '0;
    main_lines_i      = '0;
    secondary_lines_i = '0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = CFG_MAIN_EDGE;
    cfg_wdata_i       = '0;
    idle_mode         = MODE_RX_SLOW;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset edge configuration.
    send_item(ACT_SAMPLE, 7'd0, '0, '0);
    send_item(ACT_ENABLE, IRQ_FIRST_MAIN, '1, '1);
    send_item(ACT_ENABLE, IRQ_LAST_MAIN, '1, '1);
    send_item(ACT_ENABLE, IRQ_FIRST_SEC, '1, '1);
    send_item(ACT_ENABLE, 7'd41, '0, '0);
    send_item(ACT_ENABLE, 7'd49, '0, '0);
    send_item(ACT_ENABLE, IRQ_LAST_SEC, '1, '1);
    send_item(ACT_ENABLE, 7'd17, '0, '0);
    send_item(ACT_DISABLE, IRQ_FIRST_MAIN, '0, '0);
    // Acknowledge together with a fresh rising edge latches again.
    send_item(ACT_ACK, 7'd17, 32'h0001_0000, '0);
    send_item(ACT_ACK, 7'd17, '0, '0);
    send_item(ACT_ACK, 7'd49, '0, 32'h0001_0000);
    // Main IRQs five to seven act on the group enables only.
    send_item(ACT_ENABLE, 7'd5, '0, '0);
    send_item(ACT_DISABLE, 7'd7, '0, '0);
    send_item(ACT_ENABLE, 7'd7, '0, 32'h0000_0001);
    // Emptying a group also drops its main enable.
    send_item(ACT_DISABLE, IRQ_FIRST_SEC, '0, '1);
    send_item(ACT_DISABLE, 7'd41, '0, '0);
    // Selectors outside the valid range do nothing.
    send_item(ACT_DISABLE, 7'd0, '1, '1);
    send_item(ACT_ENABLE, 7'd65, '0, '0);
    send_item(ACT_ACK, 7'd127, '0, '0);
    send_item(ACT_ACK, IRQ_LAST_SEC, '1, '1);
    send_item(ACT_DISABLE, 7'd49, '0, '0);
    send_item(ACT_DISABLE, IRQ_LAST_MAIN, '0, '0);
    send_item(ACT_SAMPLE, 7'd0, '0, '0);
    settle();

    main_edge_set[0] = MAIN_EDGE_RESET;
    sec_edge_set[0]  = SEC_EDGE_RESET;
    main_edge_set[1] = '1;
    sec_edge_set[1]  = '1;
    main_edge_set[2] = '0;
    sec_edge_set[2]  = '0;
    main_edge_set[3] = $urandom;
    sec_edge_set[3]  = $urandom;
    main_edge_set[4] = '0;
    sec_edge_set[4]  = '1;
    main_edge_set[5] = '1;
    sec_edge_set[5]  = $urandom;
    main_wave = '0;
    sec_wave  = '0;

    // Random items under each edge setting, with the idling pattern stepping from RX_SLOW through TX_SLOW to STEADY.
    for (int set = 0; set < EDGE_SETS; set++) begin
      write_edges(main_edge_set[set], sec_edge_set[set]);
      idle_mode <= (set < 2) ? MODE_RX_SLOW : (set < 4) ? MODE_TX_SLOW : MODE_STEADY;
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        case ($urandom_range(9))
          0, 1:       act = ACT_SAMPLE;
          2, 3, 4, 5: act = ACT_ENABLE;
          6, 7:       act = ACT_DISABLE;
          default:    act = ACT_ACK;
        endcase
        case ($urandom_range(19))
          0:       irq = 7'd0;
          1:       irq = 7'($urandom_range(127, 65));
          default: irq = 7'($urandom_range(64, 1));
        endcase
        // Lines mostly flip a few bits at a time so that edges and levels both occur.
        case ($urandom_range(9))
          0:       main_wave = '0;
          1:       main_wave = '1;
          2, 3:    main_wave = $urandom;
          default: main_wave = main_wave ^ ($urandom & $urandom & $urandom);
        endcase
        case ($urandom_range(9))
          0:       sec_wave = '0;
          1:       sec_wave = '1;
          2, 3:    sec_wave = $urandom;
          default: sec_wave = sec_wave ^ ($urandom & $urandom & $urandom);
        endcase
        send_item(act, irq, main_wave, sec_wave);
      end
      settle();
    end

    if (mismatch_count == 0 && reports_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cmic_pkg.sv
rtl/cmic_eval.sv
rtl/cascaded_masked_interrupt_controller.sv
tb/irq_report_checker.sv
tb/cascaded_masked_interrupt_controller_tb.sv
